[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the LCD byte packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

[rtl/lcdwp_pkg.sv]
// Package with the codes and types of the LCD window and pixel byte packer.
package lcdwp_pkg;

  // Input item kinds, carried on the slave tuser.
  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Pixel format register codes.
  localparam logic [1:0] FMT_BGR444 = 2'd0;
  localparam logic [1:0] FMT_BGR565 = 2'd1;
  localparam logic [1:0] FMT_BGR666 = 2'd2;

  // Controller command bytes.
  localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WR  = 8'h2C;

  // Index of the final byte of a window item.
  localparam logic [3:0] WINDOW_LAST_IDX = 4'd10;

  // Packed bytes of one pixel and the index of its final byte.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
  } pix_t;

  // Half-pixel state kept between 12-bit pixels.
  typedef struct packed {
    logic       pending;
    logic [3:0] nibble;
  } half_t;

endpackage

[rtl/lcd_window_and_pixel_byte_packer_unit.sv]
// Top level of the LCD window and pixel byte packer.
// Usage:
//   The slave stream takes one item per beat. tuser selects the kind: a
//   window item sends column-set, four column bytes, row-set, four row
//   bytes and memory-write (11 bytes); a pixel item sends 1 to 3 bytes.
//   The master stream gives one byte per beat; tuser flags a command
//   byte and tlast marks the final byte caused by an item.
//   cfg_we_i/cfg_wdata_i write the pixel format while the block is idle.
// Timing:
//   An accepted item is packed into the item register; its first byte
//   then moves on to the output register, from which the receiver takes it.
//   The output port moves one byte per cycle while the receiver is ready;
//   a window item is 11 bytes, a pixel item 1 to 3 bytes (3 in 18-bit
//   mode, 2 in 16-bit mode, 1.5 average in 12-bit).
//   The next item is taken in the cycle its predecessor's last byte
//   moves to the output register, so items follow without a gap.
// Reset and stall:
//   Reset selects 16-bit format, drops any held half pixel and empties
//   both registers. A stalled receiver holds the output byte; the item
//   register takes at most one more item before s_axis_tready_o drops.
`include "assert_macros.svh"

module lcd_window_and_pixel_byte_packer_unit import lcdwp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,      // pixel_format
  // Slave stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // col_start[7:0], row_start[15:8], col_end[23:16], row_end[31:24],
  // red[39:32], green[47:40], blue[55:48]
  input  logic [55:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,   // kind
  // Master stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte
  output logic        m_axis_tuser_o,   // is_command
  output logic        m_axis_tlast_o    // last
);

  // Format register and half-pixel state.
  logic [1:0] fmt_q;
  half_t      half_q, half_d;

  // Item register.
  logic       busy_q, busy_d;
  logic [3:0] idx_q, idx_d;
  logic [3:0] last_idx_q;
  logic       kind_q;
  logic [7:0] col_start_q, row_start_q, col_end_q, row_end_q;
  pix_t       pix_q;

  // Output register.
  logic       m_valid_q, m_valid_d;
  logic [7:0] m_byte_q;
  logic       m_cmd_q, m_last_q;

  logic       s_fire, adv, done;
  logic       s_kind;
  pix_t       pix_new;
  half_t      half_new;
  logic [7:0] sel_byte;
  logic       sel_cmd;

  assign s_kind = s_axis_tuser_i;

  // Pack the incoming pixel against the current format and held half.
  lcdwp_pixel_pack u_pack (
    .fmt_i   (fmt_q),
    .red_i   (s_axis_tdata_i[39:32]),
    .green_i (s_axis_tdata_i[47:40]),
    .blue_i  (s_axis_tdata_i[55:48]),
    .half_i  (half_q),
    .pix_o   (pix_new),
    .half_o  (half_new)
  );

  // Handshake: the item register frees up as its last byte moves on.
  assign adv             = busy_q & (~m_valid_q | m_axis_tready_i);
  assign done            = adv & (idx_q == last_idx_q);
  assign s_axis_tready_o = ~busy_q | done;
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (s_fire) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (adv) begin
      idx_d = idx_q + 4'd1;
    end
  end

  // Held half pixel changes only with pixel items.
  always_comb begin
    half_d = half_q;
    if (s_fire && (s_kind == KIND_PIXEL)) begin
      half_d = half_new;
    end
  end

  // Byte selection for the current index of the held item.
  always_comb begin
    sel_byte = 8'h00;
    sel_cmd  = 1'b0;
    if (kind_q == KIND_WINDOW) begin
      unique case (idx_q)
        4'd0: begin
          sel_byte = CMD_COLUMN_SET;
          sel_cmd  = 1'b1;
        end
        4'd2:    sel_byte = col_start_q;
        4'd4:    sel_byte = col_end_q;
        4'd5: begin
          sel_byte = CMD_ROW_SET;
          sel_cmd  = 1'b1;
        end
        4'd7:    sel_byte = row_start_q;
        4'd9:    sel_byte = row_end_q;
        4'd10: begin
          sel_byte = CMD_MEMORY_WR;
          sel_cmd  = 1'b1;
        end
        default: sel_byte = 8'h00;
      endcase
    end else begin
      unique case (idx_q[1:0])
        2'd0:    sel_byte = pix_q.bytes[0];
        2'd1:    sel_byte = pix_q.bytes[1];
        default: sel_byte = pix_q.bytes[2];
      endcase
    end
  end

  assign m_valid_d = adv | (m_valid_q & ~m_axis_tready_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_BGR565;
      half_q    <= '0;
      busy_q    <= 1'b0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      half_q    <= half_d;
      busy_q    <= busy_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Item payload, loaded at each accepted beat.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      kind_q      <= s_kind;
      col_start_q <= s_axis_tdata_i[7:0];
      row_start_q <= s_axis_tdata_i[15:8];
      col_end_q   <= s_axis_tdata_i[23:16];
      row_end_q   <= s_axis_tdata_i[31:24];
      pix_q       <= pix_new;
      last_idx_q  <= (s_kind == KIND_WINDOW) ? WINDOW_LAST_IDX
                                             : {2'b00, pix_new.last_idx};
    end
  end

  // Output payload, loaded as a byte leaves the item register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_byte_q <= sel_byte;
      m_cmd_q  <= sel_cmd;
      m_last_q <= (idx_q == last_idx_q);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_byte_q;
  assign m_axis_tuser_o  = m_cmd_q;
  assign m_axis_tlast_o  = m_last_q;

  // The byte index never runs past the final byte of the held item.
  `ASSERT_NEVER(a_idx_in_range, busy_q && (idx_q > last_idx_q), "byte index overran item")

  // A command byte is always one of the three controller commands.
  `ASSERT_CLK(a_cmd_code, m_valid_q && m_cmd_q |-> (m_byte_q == CMD_COLUMN_SET) || (m_byte_q == CMD_ROW_SET) || (m_byte_q == CMD_MEMORY_WR), "bad command byte")

  // Every 12-bit pixel toggles the half-pixel flag.
  `ASSERT_CLK(a_half_toggle, s_fire && (s_kind == KIND_PIXEL) && (fmt_q == FMT_BGR444) |=> half_q.pending != $past(half_q.pending), "half pixel flag did not toggle")

endmodule

[rtl/lcdwp_pixel_pack.sv]
// Combinational packing of one RGB888 pixel into 12, 16 or 18-bit link bytes.
module lcdwp_pixel_pack import lcdwp_pkg::*; (
  input  logic [1:0] fmt_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  half_t      half_i,
  output pix_t       pix_o,
  output half_t      half_o
);

  always_comb begin
    pix_o  = '0;
    half_o = half_i;
    unique case (fmt_i)
      FMT_BGR444: begin
        if (half_i.pending) begin
          // Second pixel of a pair closes the three-byte group.
          pix_o.bytes[0] = {half_i.nibble, blue_i[7:4]};
          pix_o.bytes[1] = {green_i[7:4], red_i[7:4]};
          pix_o.last_idx = 2'd1;
          half_o.pending = 1'b0;
        end else begin
          // First pixel of a pair: red waits for the next pixel.
          pix_o.bytes[0] = {blue_i[7:4], green_i[7:4]};
          pix_o.last_idx = 2'd0;
          half_o.pending = 1'b1;
          half_o.nibble  = red_i[7:4];
        end
      end
      FMT_BGR565: begin
        pix_o.bytes[0] = {blue_i[7:3], green_i[7:5]};
        pix_o.bytes[1] = {green_i[4:2], red_i[7:3]};
        pix_o.last_idx = 2'd1;
      end
      default: begin
        // 18-bit mode, also used for the unassigned format code.
        pix_o.bytes[0] = blue_i;
        pix_o.bytes[1] = green_i;
        pix_o.bytes[2] = red_i;
        pix_o.last_idx = 2'd2;
      end
    endcase
  end

endmodule

[bench/tb_lcd_window_and_pixel_byte_packer_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for the LCD window and pixel byte packer, with a built-in byte predictor.
module tb_lcd_window_and_pixel_byte_packer_unit;
  import lcdwp_pkg::*;

  // The format code that the register can hold but no mode names; it behaves as 18-bit.
  localparam logic [1:0] FMT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 30;
  localparam int IDLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 18;

  // One display write as the sender sees it.
  typedef struct {
    logic       kind;
    logic [7:0] col_start;
    logic [7:0] row_start;
    logic [7:0] col_end;
    logic [7:0] row_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lcd_item_t;

  // One byte on the serial link with its flags.
  typedef struct {
    logic [7:0] data;
    logic       cmd;
    logic       last;
  } link_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        s_valid = 1'b0;
  logic [55:0] s_data = '0;
  logic        s_kind = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;
  logic        m_cmd;
  logic        m_last;

  // Predictor state: a copy of the format register and the held half pixel.
  logic [1:0]  fmt_model = FMT_BGR565;
  logic [3:0]  held_nibble = 4'd0;
  logic        half_pending = 1'b0;

  link_byte_t  pending_link_bytes[$];
  int          mismatch_count = 0;
  int          cycles = 0;
  logic        steady_flow = 1'b0;

  lcd_window_and_pixel_byte_packer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_cmd),
    .m_axis_tlast_o  (m_last)
  );

  // Clock.
  always #2 clk_i = ~clk_i;

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Print one mismatch and count it.
  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatch_count++;
    $display("[%0t] mismatch in %s: got 0x%02h, expected 0x%02h", $realtime, what, got, want);
  endtask

  // Work out the link bytes that one accepted item causes and queue them.
  function automatic void pack_item(input lcd_item_t it);
    logic [7:0] seq [11];
    logic       is_cmd [11];
    int         n;
    link_byte_t b;
    n = 0;
    for (int i = 0; i < 11; i++) begin
      seq[i] = 8'h00;
      is_cmd[i] = 1'b0;
    end
    if (it.kind == KIND_WINDOW) begin
      seq = '{CMD_COLUMN_SET, 8'h00, it.col_start, 8'h00, it.col_end,
              CMD_ROW_SET, 8'h00, it.row_start, 8'h00, it.row_end, CMD_MEMORY_WR};
      is_cmd[0] = 1'b1;
      is_cmd[5] = 1'b1;
      is_cmd[10] = 1'b1;
      n = 11;
    end else begin
      case (fmt_model)
        FMT_BGR444: begin
          // Two pixels share three bytes; the red nibble of the first waits.
          if (half_pending) begin
            seq[0] = {held_nibble, it.blue[7:4]};
            seq[1] = {it.green[7:4], it.red[7:4]};
            half_pending = 1'b0;
            n = 2;
          end else begin
            seq[0] = {it.blue[7:4], it.green[7:4]};
            held_nibble = it.red[7:4];
            half_pending = 1'b1;
            n = 1;
          end
        end
        FMT_BGR565: begin
          seq[0] = {it.blue[7:3], it.green[7:5]};
          seq[1] = {it.green[4:2], it.red[7:3]};
          n = 2;
        end
        default: begin
          seq[0] = it.blue;
          seq[1] = it.green;
          seq[2] = it.red;
          n = 3;
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      b.data = seq[i];
      b.cmd = is_cmd[i];
      b.last = (i == n - 1);
      pending_link_bytes.push_back(b);
    end
  endfunction

  // Window item; the colour fields carry noise that the block must ignore.
  function automatic lcd_item_t make_window(input logic [7:0] c0, input logic [7:0] r0,
                                            input logic [7:0] c1, input logic [7:0] r1);
    lcd_item_t it;
    it.kind = KIND_WINDOW;
    it.col_start = c0;
    it.row_start = r0;
    it.col_end = c1;
    it.row_end = r1;
    it.red = 8'($urandom_range(0, 255));
    it.green = 8'($urandom_range(0, 255));
    it.blue = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Pixel item; the window fields carry noise that the block must ignore.
  function automatic lcd_item_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    lcd_item_t it;
    it.kind = KIND_PIXEL;
    it.col_start = 8'($urandom_range(0, 255));
    it.row_start = 8'($urandom_range(0, 255));
    it.col_end = 8'($urandom_range(0, 255));
    it.row_end = 8'($urandom_range(0, 255));
    it.red = r;
    it.green = g;
    it.blue = b;
    return it;
  endfunction

  function automatic lcd_item_t random_pixel();
    return make_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
  endfunction

  function automatic lcd_item_t random_window();
    return make_window(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // Offer one item after a random gap and predict its bytes once it is taken.
  task automatic send_item(input lcd_item_t it);
    int gap;
    gap = (steady_flow || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_kind <= it.kind;
    s_data <= {it.blue, it.green, it.red, it.row_end, it.col_end, it.row_start, it.col_start};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    pack_item(it);
  endtask

  // Hold the sender until every predicted byte has arrived, then let the block settle.
  task automatic wait_for_drain();
    s_valid <= 1'b0;
    while (pending_link_bytes.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  // Change the pixel format while the block is idle.
  task automatic set_pixel_format(input logic [1:0] fmt);
    wait_for_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    fmt_model = fmt;
  endtask

  // Receiver: stalls at random and checks each beat against the oldest prediction.
  initial begin : byte_sink
    int         gap;
    link_byte_t want;
    @(posedge rst_ni);
    forever begin
      gap = (steady_flow || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_valid) @(posedge clk_i);
      if (pending_link_bytes.size() == 0) begin
        flag_mismatch("unexpected beat", m_data, 8'h00);
      end else begin
        want = pending_link_bytes.pop_front();
        if (m_data !== want.data) flag_mismatch("out_byte", m_data, want.data);
        if (m_cmd !== want.cmd) flag_mismatch("is_command", {7'd0, m_cmd}, {7'd0, want.cmd});
        if (m_last !== want.last) flag_mismatch("last", {7'd0, m_last}, {7'd0, want.last});
      end
    end
  end

  // Windows at the field extremes, plus one pixel in the format left by reset.
  task automatic test_reset_and_windows();
    send_item(make_pixel(8'hFF, 8'h5A, 8'hA5));
    send_item(make_window(8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_window(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_window(8'hAA, 8'h55, 8'h55, 8'hAA));
  endtask

  task automatic test_format_565();
    set_pixel_format(FMT_BGR565);
    send_item(make_pixel(8'h00, 8'h00, 8'h00));
    send_item(make_pixel(8'hFF, 8'hFF, 8'hFF));
    send_item(make_pixel(8'hAA, 8'h55, 8'hAA));
  endtask

  task automatic test_format_666();
    set_pixel_format(FMT_BGR666);
    send_item(make_pixel(8'h55, 8'hAA, 8'h55));
    send_item(make_pixel(8'hFF, 8'h00, 8'hFF));
  endtask

  // Half-pixel pairing, a window between halves, and a format change with a half held.
  task automatic test_format_444();
    set_pixel_format(FMT_BGR444);
    send_item(make_pixel(8'hF0, 8'h0F, 8'hA5));
    send_item(make_pixel(8'h5A, 8'hFF, 8'h00));
    send_item(make_pixel(8'hC3, 8'h3C, 8'h96));
    send_item(random_window());
    send_item(make_pixel(8'h00, 8'hFF, 8'hFF));
    send_item(random_pixel());
    set_pixel_format(FMT_BGR565);
    send_item(random_pixel());
    set_pixel_format(FMT_BGR444);
    send_item(random_pixel());
  endtask

  task automatic test_unused_format();
    set_pixel_format(FMT_UNUSED);
    send_item(make_pixel(8'h12, 8'h34, 8'h56));
    send_item(random_pixel());
  endtask

  // Random windows and pixels over several formats; one phase runs with no idling.
  task automatic test_random_traffic();
    logic [1:0] formats [8];
    formats = '{FMT_BGR444, FMT_BGR666, FMT_BGR565, FMT_BGR444,
                FMT_UNUSED, FMT_BGR565, FMT_BGR444, FMT_BGR666};
    foreach (formats[p]) begin
      set_pixel_format(formats[p]);
      steady_flow = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 7) == 0) send_item(random_window());
        else send_item(random_pixel());
        // The sender stops once mid-phase until every byte is out.
        if (p == 5 && i == PHASE_ITEMS / 2) wait_for_drain();
      end
      steady_flow = 1'b0;
    end
  endtask

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_windows();
    test_format_565();
    test_format_666();
    test_format_444();
    test_unused_format();
    test_random_traffic();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_link_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
